// ===== src/ptps_pkg.sv =====
package ptps_pkg;

  typedef enum logic [3:0] {
    ACT_ALLOC    = 4'd0,
    ACT_READY    = 4'd1,
    ACT_SLEEP    = 4'd2,
    ACT_WAKE     = 4'd3,
    ACT_KILL     = 4'd4,
    ACT_SETPRIO  = 4'd5,
    ACT_GETPRIO  = 4'd6,
    ACT_EXIT     = 4'd7,
    ACT_REAP     = 4'd8,
    ACT_POSITION = 4'd9
  } ptps_action_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_RANGE     = 3'd3,
    STS_NONE      = 3'd4
  } ptps_status_t;

  typedef enum logic [2:0] {
    E_UNUSED   = 3'd0,
    E_EMBRYO   = 3'd1,
    E_SLEEPING = 3'd2,
    E_RUNNABLE = 3'd3,
    E_RUNNING  = 3'd4,
    E_ZOMBIE   = 3'd5
  } ptps_estate_t;

  localparam logic CFG_DEFAULT_PRIO = 1'b0;
  localparam logic CFG_PRIO_LEVELS  = 1'b1;

  localparam logic [3:0] RST_DEFAULT_PRIO = 4'd5;
  localparam logic [3:0] RST_PRIO_LEVELS  = 4'd10;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic fin;
  } ptps_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic out_busy;
  } ptps_sts_t;

endpackage

// ===== src/ptps_ctrl.sv =====
module ptps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptps_pkg::ptps_sts_t sts,
  output ptps_pkg::ptps_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state_r;
  logic   in_stall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (sts.addr_last) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_SCAN;
            in_stall_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (sts.addr_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!sts.out_busy) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_CLEAR;
          in_stall_r <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd.clr  = (state_r == S_CLEAR);
    cmd.load = (state_r == S_IDLE) && in_valid;
    cmd.rd   = (state_r == S_SCAN);
    cmd.fin  = (state_r == S_FIN) && !sts.out_busy;
  end

  assign in_stall = in_stall_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall_r |-> state_r == S_IDLE)
    else $error("input taken outside idle");

  a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SCAN) && in_stall_r)
    else $error("accepted word did not start a scan");

  a_drain_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |=> state_r == S_FIN)
    else $error("drain did not lead to finish");

  a_scan_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !sts.addr_last) |=> state_r == S_SCAN)
    else $error("scan ended early");

endmodule

// ===== src/ptps_dpath.sv =====
module ptps_dpath #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ID_BITS       = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptps_pkg::ptps_cmd_t cmd,
  output ptps_pkg::ptps_sts_t sts,
  input  logic [3:0]          in_action,
  input  logic                in_pick_request,
  input  logic [15:0]         in_task_id,
  input  logic [7:0]          in_channel,
  input  logic [3:0]          in_priority_req,
  input  logic [3:0]          def_prio,
  input  logic [3:0]          levels,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [15:0]         out_task_out,
  output logic [5:0]          out_slot,
  output logic [6:0]          out_value
);

  localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS  = $clog2(TABLE_ENTRIES + 1);

  ptps_pkg::ptps_estate_t mem_state [TABLE_ENTRIES];
  logic [ID_BITS-1:0]     mem_id    [TABLE_ENTRIES];
  logic [3:0]             mem_prio  [TABLE_ENTRIES];
  logic [7:0]             mem_chan  [TABLE_ENTRIES];

  ptps_pkg::ptps_estate_t rd_state_r;
  logic [ID_BITS-1:0]     rd_id_r;
  logic [3:0]             rd_prio_r;
  logic [7:0]             rd_chan_r;

  logic [SLOT_BITS-1:0]   addr_r;
  logic [SLOT_BITS-1:0]   raddr_r;
  logic                   rvalid_r;

  ptps_pkg::ptps_action_t act_r;
  logic                   pick_r;
  logic [ID_BITS-1:0]     id_r;
  logic [7:0]             chan_r;
  logic [3:0]             preq_r;

  logic                   found_r;
  logic [SLOT_BITS-1:0]   fslot_r;
  ptps_pkg::ptps_estate_t fstate_r;
  logic [3:0]             fprio_r;

  logic                   best_r;
  logic [SLOT_BITS-1:0]   bslot_r;
  logic [3:0]             bprio_r;
  logic [ID_BITS-1:0]     bid_r;

  logic                   free_r;
  logic [SLOT_BITS-1:0]   free_slot_r;

  logic                   pos_r;
  logic [SLOT_BITS-1:0]   pslot_r;
  logic [CNT_BITS-1:0]    cnt_r;

  logic [ID_BITS-1:0]     next_id_r;

  logic                   out_valid_r;
  logic [2:0]             out_status_r;
  logic [15:0]            out_task_r;
  logic [5:0]             out_slot_r;
  logic [6:0]             out_value_r;

  logic                   used;
  logic                   id_hit;
  logic                   wake_hit;
  logic                   pos_count;
  logic [4:0]             best_lim;

  logic                   we_state;
  logic                   we_id;
  logic                   we_prio;
  logic                   we_chan;
  logic [SLOT_BITS-1:0]   waddr;
  ptps_pkg::ptps_estate_t wstate;
  logic [ID_BITS-1:0]     wid;
  logic [3:0]             wprio;
  logic [7:0]             wchan;

  logic                   f_we_state;
  logic                   f_we_id;
  logic                   f_we_prio;
  logic                   f_we_chan;
  logic [SLOT_BITS-1:0]   f_addr;
  ptps_pkg::ptps_estate_t f_state;
  logic [3:0]             f_prio;
  logic [7:0]             f_chan;
  logic                   alloc_go;
  ptps_pkg::ptps_status_t o_status;
  logic [ID_BITS-1:0]     o_task;
  logic [SLOT_BITS-1:0]   o_slot;
  logic [6:0]             o_value;

  assign used      = rd_state_r != ptps_pkg::E_UNUSED;
  assign id_hit    = rd_id_r == id_r;
  assign wake_hit  = rvalid_r && !pick_r && (act_r == ptps_pkg::ACT_WAKE) &&
                     (rd_state_r == ptps_pkg::E_SLEEPING) && (rd_chan_r == chan_r);
  assign pos_count = rvalid_r && !pick_r && (act_r == ptps_pkg::ACT_POSITION) &&
                     !pos_r && (rd_state_r == ptps_pkg::E_RUNNABLE) && !id_hit;
  assign best_lim  = best_r ? {1'b0, bprio_r} : ({1'b0, levels} + 5'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      rvalid_r  <= 1'b0;
      next_id_r <= ID_BITS'(1);
    end else begin
      rvalid_r <= cmd.rd;
      raddr_r  <= addr_r;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.rd || cmd.clr) begin
        addr_r <= addr_r + 1'b1;
      end
      if (cmd.fin && alloc_go) begin
        next_id_r <= next_id_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= ptps_pkg::ptps_action_t'(in_action);
      pick_r  <= in_pick_request;
      id_r    <= ID_BITS'(in_task_id);
      chan_r  <= in_channel;
      preq_r  <= in_priority_req;
      found_r <= 1'b0;
      best_r  <= 1'b0;
      free_r  <= 1'b0;
      pos_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (rvalid_r) begin
      if (!found_r && used && id_hit) begin
        found_r  <= 1'b1;
        fslot_r  <= raddr_r;
        fstate_r <= rd_state_r;
        fprio_r  <= rd_prio_r;
      end
      if (rd_state_r == ptps_pkg::E_RUNNABLE && {1'b0, rd_prio_r} < best_lim) begin
        best_r  <= 1'b1;
        bslot_r <= raddr_r;
        bprio_r <= rd_prio_r;
        bid_r   <= rd_id_r;
      end
      if (!free_r && !used) begin
        free_r      <= 1'b1;
        free_slot_r <= raddr_r;
      end
      if (!pos_r && rd_state_r == ptps_pkg::E_RUNNABLE && id_hit) begin
        pos_r   <= 1'b1;
        pslot_r <= raddr_r;
      end
      if (wake_hit || pos_count) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    f_we_state = 1'b0;
    f_we_id    = 1'b0;
    f_we_prio  = 1'b0;
    f_we_chan  = 1'b0;
    f_addr     = fslot_r;
    f_state    = ptps_pkg::E_UNUSED;
    f_prio     = preq_r;
    f_chan     = chan_r;
    alloc_go   = 1'b0;
    o_status   = ptps_pkg::STS_OK;
    o_task     = '0;
    o_slot     = '0;
    o_value    = '0;
    if (pick_r) begin
      if (best_r) begin
        f_we_state = 1'b1;
        f_addr     = bslot_r;
        f_state    = ptps_pkg::E_RUNNING;
        o_task     = bid_r;
        o_slot     = bslot_r;
        o_value    = 7'(bprio_r);
      end else begin
        o_status = ptps_pkg::STS_NONE;
      end
    end else begin
      unique case (act_r) inside
        ptps_pkg::ACT_ALLOC: begin
          if (free_r) begin
            f_we_state = 1'b1;
            f_we_id    = 1'b1;
            f_we_prio  = 1'b1;
            f_we_chan  = 1'b1;
            f_addr     = free_slot_r;
            f_state    = ptps_pkg::E_EMBRYO;
            f_prio     = def_prio;
            f_chan     = '0;
            alloc_go   = 1'b1;
            o_task     = next_id_r;
            o_slot     = free_slot_r;
            o_value    = 7'(def_prio);
          end else begin
            o_status = ptps_pkg::STS_FULL;
          end
        end
        ptps_pkg::ACT_WAKE: begin
          o_value = 7'(cnt_r);
        end
        ptps_pkg::ACT_POSITION: begin
          if (pos_r) begin
            o_task  = id_r;
            o_slot  = pslot_r;
            o_value = 7'(cnt_r);
          end else begin
            o_status = ptps_pkg::STS_NOT_FOUND;
          end
        end
        ptps_pkg::ACT_READY, ptps_pkg::ACT_SLEEP, ptps_pkg::ACT_KILL,
        ptps_pkg::ACT_SETPRIO, ptps_pkg::ACT_GETPRIO, ptps_pkg::ACT_EXIT,
        ptps_pkg::ACT_REAP: begin
          if (act_r == ptps_pkg::ACT_SETPRIO && (preq_r == 4'd0 || preq_r > levels)) begin
            o_status = ptps_pkg::STS_RANGE;
          end else if (!found_r) begin
            o_status = ptps_pkg::STS_NOT_FOUND;
          end else begin
            case (act_r)
              ptps_pkg::ACT_READY: begin
                if (fstate_r == ptps_pkg::E_ZOMBIE) begin
                  o_status = ptps_pkg::STS_NOT_FOUND;
                end else begin
                  f_we_state = 1'b1;
                  f_state    = ptps_pkg::E_RUNNABLE;
                end
              end
              ptps_pkg::ACT_SLEEP: begin
                if (fstate_r == ptps_pkg::E_ZOMBIE) begin
                  o_status = ptps_pkg::STS_NOT_FOUND;
                end else begin
                  f_we_state = 1'b1;
                  f_we_chan  = 1'b1;
                  f_state    = ptps_pkg::E_SLEEPING;
                end
              end
              ptps_pkg::ACT_KILL: begin
                if (fstate_r == ptps_pkg::E_SLEEPING) begin
                  f_we_state = 1'b1;
                  f_state    = ptps_pkg::E_RUNNABLE;
                end
              end
              ptps_pkg::ACT_SETPRIO: begin
                f_we_prio = 1'b1;
                o_value   = 7'(preq_r);
              end
              ptps_pkg::ACT_GETPRIO: begin
                o_value = 7'(fprio_r);
              end
              ptps_pkg::ACT_EXIT: begin
                if (fstate_r == ptps_pkg::E_ZOMBIE) begin
                  o_status = ptps_pkg::STS_NOT_FOUND;
                end else begin
                  f_we_state = 1'b1;
                  f_state    = ptps_pkg::E_ZOMBIE;
                end
              end
              default: begin
                if (fstate_r != ptps_pkg::E_ZOMBIE) begin
                  o_status = ptps_pkg::STS_NOT_FOUND;
                end else begin
                  f_we_state = 1'b1;
                  f_state    = ptps_pkg::E_UNUSED;
                end
              end
            endcase
            if (o_status == ptps_pkg::STS_OK) begin
              o_task = id_r;
              o_slot = fslot_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    we_state = 1'b0;
    we_id    = 1'b0;
    we_prio  = 1'b0;
    we_chan  = 1'b0;
    waddr    = f_addr;
    wstate   = f_state;
    wid      = next_id_r;
    wprio    = f_prio;
    wchan    = f_chan;
    if (cmd.clr) begin
      we_state = 1'b1;
      waddr    = addr_r;
      wstate   = ptps_pkg::E_UNUSED;
    end else if (wake_hit) begin
      we_state = 1'b1;
      waddr    = raddr_r;
      wstate   = ptps_pkg::E_RUNNABLE;
    end else if (cmd.fin) begin
      we_state = f_we_state;
      we_id    = f_we_id;
      we_prio  = f_we_prio;
      we_chan  = f_we_chan;
    end
  end

  always_ff @(posedge clk) begin
    if (we_state) begin
      mem_state[waddr] <= wstate;
    end
    if (we_id) begin
      mem_id[waddr] <= wid;
    end
    if (we_prio) begin
      mem_prio[waddr] <= wprio;
    end
    if (we_chan) begin
      mem_chan[waddr] <= wchan;
    end
    rd_state_r <= mem_state[addr_r];
    rd_id_r    <= mem_id[addr_r];
    rd_prio_r  <= mem_prio[addr_r];
    rd_chan_r  <= mem_chan[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_status_r <= o_status;
      out_task_r   <= 16'(o_task);
      out_slot_r   <= 6'(o_slot);
      out_value_r  <= o_value;
    end
  end

  always_comb begin
    sts.addr_last = addr_r == SLOT_BITS'(TABLE_ENTRIES - 1);
    sts.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_task_out = out_task_r;
  assign out_slot     = out_slot_r;
  assign out_value    = out_value_r;

endmodule

// ===== src/process_table_priority_scheduler.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  action, pick_request, task_id, channel, priority_req
// out      output     out_valid / out_stall status, task_out, slot, value
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// After a word is accepted its result is formed in one pass over the task table memory,
// one entry read per cycle, then a drain step for the last read, then a finish step that
// makes the result valid. Input stays stalled until then, so the next word is taken
// only once the finish step has returned to idle. After reset the table states are cleared
// in a pass during which no input word is taken; configuration writes are always taken.
// A result waiting under out_stall holds the finish step; the word on the output stays until taken.
module process_table_priority_scheduler #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ID_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic        in_pick_request,
  input  logic [15:0] in_task_id,
  input  logic [7:0]  in_channel,
  input  logic [3:0]  in_priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_task_out,
  output logic [5:0]  out_slot,
  output logic [6:0]  out_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  ptps_pkg::ptps_cmd_t cmd;
  ptps_pkg::ptps_sts_t sts;
  logic [3:0]          def_prio_r;
  logic [3:0]          levels_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_prio_r <= ptps_pkg::RST_DEFAULT_PRIO;
      levels_r   <= ptps_pkg::RST_PRIO_LEVELS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptps_pkg::CFG_DEFAULT_PRIO: def_prio_r <= cfg_data;
        ptps_pkg::CFG_PRIO_LEVELS:  levels_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ptps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptps_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ID_BITS       (ID_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_pick_request (in_pick_request),
    .in_task_id      (in_task_id),
    .in_channel      (in_channel),
    .in_priority_req (in_priority_req),
    .def_prio        (def_prio_r),
    .levels          (levels_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_task_out    (out_task_out),
    .out_slot        (out_slot),
    .out_value       (out_value)
  );

endmodule
